// ===== rtl/sdsch_pkg.sv =====
// ----------------------------------------------------------------------------
// sdsch_pkg
// Shared types and constants of the SCAN disk scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package sdsch_pkg;

	localparam int TRACK_W = 16;
	localparam int SEEK_W  = 22;
	localparam int ADDR_W  = 4;
	localparam int DATA_W  = 32;

	localparam logic [SEEK_W-1:0] SEEK_MAX = 22'h3FFFFF;

	// Register indexes (byte address divided by four).
	localparam logic [1:0] REG_HEAD_START = 2'd0;
	localparam logic [1:0] REG_MAX_TRACK  = 2'd1;
	localparam logic [1:0] REG_SWEEP_DIR  = 2'd2;

	// Sweep direction codes.
	localparam logic DIR_UP   = 1'b0;
	localparam logic DIR_DOWN = 1'b1;

	typedef struct packed {
		logic [TRACK_W-1:0] head_start;
		logic [TRACK_W-1:0] max_track;
		logic               sweep_dir;
	} cfg_t;

endpackage

`default_nettype wire

// ===== rtl/sdsch_if.sv =====
// ----------------------------------------------------------------------------
// sdsch_req_if / sdsch_res_if
// Valid/ready channels for track requests and for scheduled tracks.
// ----------------------------------------------------------------------------
`default_nettype none

interface sdsch_req_if;
	logic                        valid;
	logic                        ready;
	logic [sdsch_pkg::TRACK_W-1:0] track;
	logic                        last_req;

	modport source (output valid, output track, output last_req, input ready);
	modport sink   (input valid, input track, input last_req, output ready);
endinterface

interface sdsch_res_if;
	logic                          valid;
	logic                          ready;
	logic [sdsch_pkg::TRACK_W-1:0] serve_track;
	logic [sdsch_pkg::SEEK_W-1:0]  seek_total;
	logic                          last_out;

	modport source (output valid, output serve_track, output seek_total, output last_out,
		input ready);
	modport sink   (input valid, input serve_track, input seek_total, input last_out,
		output ready);
endinterface

`default_nettype wire

// ===== rtl/sdsch_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// sdsch_cfg_regs
// APB register file holding head start, maximum track and sweep direction.
// ----------------------------------------------------------------------------
`default_nettype none

module sdsch_cfg_regs (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [sdsch_pkg::ADDR_W-1:0] paddr,
	input  wire logic [sdsch_pkg::DATA_W-1:0] pwdata,
	output logic      [sdsch_pkg::DATA_W-1:0] prdata,
	output logic                              pready,
	output sdsch_pkg::cfg_t                   cfg
);
	import sdsch_pkg::*;

	logic [TRACK_W-1:0] head_start_q;
	logic [TRACK_W-1:0] max_track_q;
	logic               sweep_dir_q;
	logic               wr_en;
	logic [1:0]         reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_start_q <= '0;
			max_track_q  <= '1;
			sweep_dir_q  <= DIR_UP;
		end else if (wr_en) begin
			case (reg_idx)
				REG_HEAD_START: head_start_q <= pwdata[TRACK_W-1:0];
				REG_MAX_TRACK:  max_track_q  <= pwdata[TRACK_W-1:0];
				REG_SWEEP_DIR:  sweep_dir_q  <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (reg_idx)
			REG_HEAD_START: prdata[TRACK_W-1:0] = head_start_q;
			REG_MAX_TRACK:  prdata[TRACK_W-1:0] = max_track_q;
			REG_SWEEP_DIR:  prdata[0]           = sweep_dir_q;
			default:        prdata = '0;
		endcase
	end

	assign cfg.head_start = head_start_q;
	assign cfg.max_track  = max_track_q;
	assign cfg.sweep_dir  = sweep_dir_q;

endmodule

`default_nettype wire

// ===== rtl/sdsch_list_ram.sv =====
// ----------------------------------------------------------------------------
// sdsch_list_ram
// Simple dual-port track memory, one write and one registered read a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sdsch_list_ram #(
	parameter int DEPTH = 32
) (
	input  wire logic                             clk,
	input  wire logic                             we,
	input  wire logic [$clog2(DEPTH)-1:0]         waddr,
	input  wire logic [sdsch_pkg::TRACK_W-1:0]    wdata,
	input  wire logic [$clog2(DEPTH)-1:0]         raddr,
	output logic      [sdsch_pkg::TRACK_W-1:0]    rdata
);
	import sdsch_pkg::*;

	logic [TRACK_W-1:0] mem [DEPTH];
	logic [TRACK_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/sdsch_engine.sv =====
// ----------------------------------------------------------------------------
// sdsch_engine
// Sorted insertion into the lower and upper list memories, then SCAN playout.
// ----------------------------------------------------------------------------
`default_nettype none

module sdsch_engine #(
	parameter int MAX_REQS = 32
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  sdsch_pkg::cfg_t      cfg,
	sdsch_req_if.sink            req,
	sdsch_res_if.source          res
);
	import sdsch_pkg::*;

	localparam int AW = $clog2(MAX_REQS);
	localparam int CW = $clog2(MAX_REQS + 1);

	typedef enum logic [2:0] {
		ST_IDLE, ST_INS, ST_PUT0, ST_EMIT, ST_FETCH
	} state_t;

	typedef enum logic [1:0] {
		PH_FIRST, PH_BOUND, PH_SECOND
	} phase_t;

	state_t             state_q;
	phase_t             phase_q;
	logic               sel_up_q;
	logic               last_q;
	logic [TRACK_W-1:0] val_q;
	logic [AW-1:0]      idx_q;
	logic [CW-1:0]      lcnt_q;
	logic [CW-1:0]      ucnt_q;
	logic [CW-1:0]      eidx_q;
	logic [TRACK_W-1:0] head_q;
	logic [SEEK_W-1:0]  sum_q;
	logic               out_valid_q;
	logic [TRACK_W-1:0] out_track_q;
	logic [SEEK_W-1:0]  out_sum_q;
	logic               out_last_q;

	logic [AW-1:0]      rd_addr;
	logic               wr_en;
	logic               wr_up;
	logic [AW-1:0]      wr_addr;
	logic [TRACK_W-1:0] wr_data;
	logic [TRACK_W-1:0] lo_rd;
	logic [TRACK_W-1:0] up_rd;

	logic               in_acc;
	logic               in_up;
	logic [CW-1:0]      in_cnt;
	logic [CW-1:0]      in_cnt_m1;
	logic [CW:0]        total;
	logic               room;
	logic [TRACK_W-1:0] ins_rd;
	logic               ins_shift;
	logic [AW-1:0]      idx_m1;

	logic               emit_up;
	logic [CW-1:0]      cnt_cur;
	logic [CW-1:0]      cnt_second;
	logic [CW-1:0]      eidx_p1;
	logic [TRACK_W-1:0] emit_rd;
	logic               out_free;
	logic               out_load;
	logic [TRACK_W-1:0] bound_track;

	logic [TRACK_W-1:0] prod_track;
	logic [TRACK_W-1:0] seek_step;
	logic [SEEK_W:0]    sum_wide;
	logic [SEEK_W-1:0]  sum_next;

	sdsch_list_ram #(.DEPTH(MAX_REQS)) u_lower (
		.clk   (clk),
		.we    (wr_en & ~wr_up),
		.waddr (wr_addr),
		.wdata (wr_data),
		.raddr (rd_addr),
		.rdata (lo_rd)
	);

	sdsch_list_ram #(.DEPTH(MAX_REQS)) u_upper (
		.clk   (clk),
		.we    (wr_en & wr_up),
		.waddr (wr_addr),
		.wdata (wr_data),
		.raddr (rd_addr),
		.rdata (up_rd)
	);

	assign req.ready = (state_q == ST_IDLE);
	assign in_acc    = req.valid & req.ready;
	assign in_up     = (req.track >= cfg.head_start);
	assign in_cnt    = in_up ? ucnt_q : lcnt_q;
	assign in_cnt_m1 = in_cnt - CW'(1);
	assign total     = {1'b0, lcnt_q} + {1'b0, ucnt_q};
	assign room      = (total < (CW+1)'(MAX_REQS));

	// A write straight from the input goes to the list of the incoming track.
	assign wr_up     = (state_q == ST_IDLE) ? in_up : sel_up_q;

	assign ins_rd    = sel_up_q ? up_rd : lo_rd;
	assign ins_shift = sel_up_q ? (ins_rd > val_q) : (ins_rd < val_q);
	assign idx_m1    = idx_q - AW'(1);

	// The first list swept is the upper one when sweeping up, else the lower one.
	assign emit_up     = (phase_q == PH_FIRST) ? (cfg.sweep_dir == DIR_UP)
		: (cfg.sweep_dir == DIR_DOWN);
	assign cnt_cur     = emit_up ? ucnt_q : lcnt_q;
	assign cnt_second  = (cfg.sweep_dir == DIR_UP) ? lcnt_q : ucnt_q;
	assign eidx_p1     = eidx_q + CW'(1);
	assign emit_rd     = emit_up ? up_rd : lo_rd;
	assign out_free    = ~out_valid_q | res.ready;
	assign out_load    = out_free & ((state_q == ST_FETCH) |
		((state_q == ST_EMIT) & (phase_q == PH_BOUND)));
	assign bound_track = (cfg.sweep_dir == DIR_UP) ? cfg.max_track : '0;

	// Track that would be produced in this cycle, with its seek distance.
	assign prod_track = (state_q == ST_FETCH) ? emit_rd : bound_track;
	assign seek_step  = (prod_track > head_q) ? (prod_track - head_q)
		: (head_q - prod_track);
	assign sum_wide   = {1'b0, sum_q} + {{(SEEK_W+1-TRACK_W){1'b0}}, seek_step};
	assign sum_next   = (sum_wide > {1'b0, SEEK_MAX}) ? SEEK_MAX : sum_wide[SEEK_W-1:0];

	// The read address follows the insertion walk or the playout index. A write
	// during insertion lands two entries above every read whose data is used, so no bypass is needed.
	always_comb begin
		rd_addr = eidx_q[AW-1:0];
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = val_q;
		case (state_q)
			ST_IDLE: begin
				rd_addr = in_cnt_m1[AW-1:0];
				if (in_acc && room && in_cnt == '0) begin
					wr_en   = 1'b1;
					wr_data = req.track;
				end
			end
			ST_INS: begin
				wr_en   = 1'b1;
				wr_addr = idx_q + AW'(1);
				wr_data = ins_shift ? ins_rd : val_q;
				rd_addr = idx_m1;
			end
			ST_PUT0: begin
				wr_en = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= PH_FIRST;
			lcnt_q      <= '0;
			ucnt_q      <= '0;
			eidx_q      <= '0;
			idx_q       <= '0;
			sel_up_q    <= 1'b0;
			last_q      <= 1'b0;
			val_q       <= '0;
			head_q      <= '0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
			out_track_q <= '0;
			out_sum_q   <= '0;
			out_last_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						sel_up_q <= in_up;
						val_q    <= req.track;
						last_q   <= req.last_req;
						idx_q    <= in_cnt_m1[AW-1:0];
						if (room && in_cnt != '0) begin
							state_q <= ST_INS;
						end else begin
							if (room) begin
								if (in_up) ucnt_q <= ucnt_q + CW'(1);
								else       lcnt_q <= lcnt_q + CW'(1);
							end
							if (req.last_req) begin
								state_q <= ST_EMIT;
								phase_q <= PH_FIRST;
								eidx_q  <= '0;
								head_q  <= cfg.head_start;
								sum_q   <= '0;
							end
						end
					end
				end
				ST_INS: begin
					if (ins_shift && idx_q != '0) begin
						idx_q <= idx_m1;
					end else if (ins_shift) begin
						state_q <= ST_PUT0;
					end else begin
						if (sel_up_q) ucnt_q <= ucnt_q + CW'(1);
						else          lcnt_q <= lcnt_q + CW'(1);
						state_q <= last_q ? ST_EMIT : ST_IDLE;
						phase_q <= PH_FIRST;
						eidx_q  <= '0;
						head_q  <= cfg.head_start;
						sum_q   <= '0;
					end
				end
				ST_PUT0: begin
					if (sel_up_q) ucnt_q <= ucnt_q + CW'(1);
					else          lcnt_q <= lcnt_q + CW'(1);
					state_q <= last_q ? ST_EMIT : ST_IDLE;
					phase_q <= PH_FIRST;
					eidx_q  <= '0;
					head_q  <= cfg.head_start;
					sum_q   <= '0;
				end
				ST_EMIT: begin
					case (phase_q)
						PH_FIRST, PH_SECOND: begin
							if (eidx_q < cnt_cur) begin
								state_q <= ST_FETCH;
							end else if (phase_q == PH_FIRST) begin
								phase_q <= PH_BOUND;
								eidx_q  <= '0;
							end else begin
								state_q <= ST_IDLE;
							end
						end
						PH_BOUND: begin
							if (out_free) begin
								out_track_q <= prod_track;
								out_sum_q   <= sum_next;
								out_last_q  <= (cnt_second == '0);
								head_q      <= prod_track;
								sum_q       <= sum_next;
								phase_q     <= PH_SECOND;
								eidx_q      <= '0;
								if (cnt_second == '0) begin
									state_q <= ST_IDLE;
									lcnt_q  <= '0;
									ucnt_q  <= '0;
								end
							end
						end
						default: state_q <= ST_IDLE;
					endcase
				end
				ST_FETCH: begin
					if (out_free) begin
						out_track_q <= prod_track;
						out_sum_q   <= sum_next;
						out_last_q  <= (phase_q == PH_SECOND) && (eidx_p1 == cnt_cur);
						head_q      <= prod_track;
						sum_q       <= sum_next;
						eidx_q      <= eidx_p1;
						if ((phase_q == PH_SECOND) && (eidx_p1 == cnt_cur)) begin
							state_q <= ST_IDLE;
							lcnt_q  <= '0;
							ucnt_q  <= '0;
						end else begin
							state_q <= ST_EMIT;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign res.valid       = out_valid_q;
	assign res.serve_track = out_track_q;
	assign res.seek_total  = out_sum_q;
	assign res.last_out    = out_last_q;

endmodule

`default_nettype wire

// ===== rtl/scan_disk_scheduler_unit.sv =====
// ----------------------------------------------------------------------------
// scan_disk_scheduler_unit
// SCAN (elevator) disk scheduler: collects a batch of track requests and
// plays them back in sweep order with a running seek total.
// ----------------------------------------------------------------------------
// Usage:
// Track requests arrive on the req channel, one beat per request. Each is sorted
// into the lower list (below the head) or the upper list (at or above it), both
// held in memories with a registered read. Insertion walks the target list from its
// top, moving one entry a cycle, so a request is written straight into an empty list,
// while in a list that already holds entries the walk goes on as long as it has
// entries to pass. Requests beyond MAX_REQS are dropped, though their last_req mark
// still closes the batch.
// The beat with last_req set starts playout on the res channel: each listed track
// is read from memory, then registered; the sweep boundary comes between the two lists.
// No request is taken during playout; the final result may still wait in the
// output register while the next batch already comes in. A stalled receiver
// simply holds the output register and playout waits. Reset empties both lists,
// clears the output and loads the register defaults; the memories need no clearing.
// Configuration is an APB port: head_start at 0x0, max_track at 0x4, sweep_dir at 0x8.
// ----------------------------------------------------------------------------
`default_nettype none

module scan_disk_scheduler_unit #(
	parameter int MAX_REQS = 32
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	sdsch_req_if.sink                         req,
	sdsch_res_if.source                       res,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [sdsch_pkg::ADDR_W-1:0] paddr,
	input  wire logic [sdsch_pkg::DATA_W-1:0] pwdata,
	output logic      [sdsch_pkg::DATA_W-1:0] prdata,
	output logic                              pready
);
	import sdsch_pkg::*;

	cfg_t cfg;

	// Register file; the engine classifies each incoming request against head_start
	// and loads it as the head position at the start of every playout.
	sdsch_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Insertion and playout engine with the two list memories.
	sdsch_engine #(.MAX_REQS(MAX_REQS)) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.req    (req),
		.res    (res)
	);

endmodule

`default_nettype wire
